// ----- design/bssi_pkg.sv -----
// ----------------------------------------------------------------------------
// bssi_pkg
// Shared types and constants for the bounded sorted string insert block.
// ----------------------------------------------------------------------------
package bssi_pkg;

    // default sizes of the list
    localparam int SLOTS_DEF     = 16;
    localparam int MAX_CHARS_DEF = 16;

    // stream word widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int POS_W      = 4;
    localparam int OCC_W      = 5;
    localparam int OCC_MAX    = 31;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_CP_RD,
        ST_CP_WR,
        ST_WR_RD,
        ST_WR_WR,
        ST_DONE
    } t_state;

    // outcome of one step of the byte compare unit
    typedef struct packed {
        logic done;
        logic not_below;
    } t_cmp_res;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic     accept;
        logic     last;
        logic     at_tail;
        logic     full;
        t_cmp_res cmp;
        logic     k_end;
        logic     start_eq;
        logic     next_eq;
        logic     out_free;
    } t_seq_sts;

    // controls from the sequencer to the datapath
    typedef struct packed {
        logic ready;
        logic clr_pos;
        logic clr_k;
        logic inc_k;
        logic inc_pos;
        logic set_found;
        logic clr_found;
        logic load_j;
        logic dec_j;
        logic rd_copy;
        logic slot_we_copy;
        logic slot_we_store;
        logic len_we_copy;
        logic len_we_store;
        logic inc_count;
        logic load_out;
        logic clr_stage;
    } t_seq_ctl;

endpackage

// ----- design/bssi_ram.sv -----
// ----------------------------------------------------------------------------
// bssi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bssi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/bssi_cmp.sv -----
// ----------------------------------------------------------------------------
// bssi_cmp
// Shared byte compare unit: one step of the lexicographic string compare.
// ----------------------------------------------------------------------------
module bssi_cmp
    import bssi_pkg::*;
#(
    parameter int CHAR_W = 4,
    parameter int LEN_W  = 5
) (
    input  logic [7:0]        i_slot_byte,
    input  logic [7:0]        i_stage_byte,
    input  logic [CHAR_W-1:0] i_k,
    input  logic [LEN_W-1:0]  i_slot_len,
    input  logic [LEN_W-1:0]  i_stage_len,
    output t_cmp_res          o_res
);

    logic [LEN_W-1:0] w_n;
    logic [LEN_W-1:0] w_k;

    // common length and byte index at length width
    assign w_n = (i_slot_len < i_stage_len) ? i_slot_len : i_stage_len;
    assign w_k = LEN_W'(i_k);

    // differing byte decides; past the common part the lengths decide
    always_comb begin
        o_res = '0;
        if (w_k < w_n) begin
            if (i_slot_byte != i_stage_byte) begin
                o_res.done      = 1'b1;
                o_res.not_below = i_slot_byte > i_stage_byte;
            end else if (w_k == w_n - LEN_W'(1)) begin
                o_res.done      = 1'b1;
                o_res.not_below = i_slot_len >= i_stage_len;
            end
        end else begin
            o_res.done      = 1'b1;
            o_res.not_below = i_slot_len >= i_stage_len;
        end
    end

endmodule

// ----- design/bssi_seq.sv -----
// ----------------------------------------------------------------------------
// bssi_seq
// Sequencer: search, shift down and store phases of one string insertion.
// ----------------------------------------------------------------------------
module bssi_seq
    import bssi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seq_sts i_sts,
    output t_seq_ctl o_ctl
);

    t_state r_state;
    t_state n_state;
    t_state w_found_st;

    // after a hit go straight to storing when no slot has to move
    assign w_found_st = i_sts.start_eq ? ST_WR_RD : ST_CP_RD;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_sts.accept && i_sts.last) begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (i_sts.at_tail) begin
                    n_state = i_sts.full ? ST_DONE : w_found_st;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.cmp.done && i_sts.cmp.not_below) begin
                    n_state = w_found_st;
                end else begin
                    n_state = ST_SRCH;
                end
            end
            ST_CP_RD: begin
                n_state = ST_CP_WR;
            end
            ST_CP_WR: begin
                if (i_sts.k_end && i_sts.next_eq) begin
                    n_state = ST_WR_RD;
                end else begin
                    n_state = ST_CP_RD;
                end
            end
            ST_WR_RD: begin
                n_state = ST_WR_WR;
            end
            ST_WR_WR: begin
                n_state = i_sts.k_end ? ST_DONE : ST_WR_RD;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.ready = 1'b1;
                if (i_sts.accept && i_sts.last) begin
                    o_ctl.clr_pos = 1'b1;
                    o_ctl.clr_k   = 1'b1;
                end
            end
            ST_SRCH: begin
                if (i_sts.at_tail) begin
                    if (i_sts.full) begin
                        o_ctl.clr_found = 1'b1;
                    end else begin
                        o_ctl.set_found = 1'b1;
                        o_ctl.load_j    = 1'b1;
                        o_ctl.clr_k     = 1'b1;
                    end
                end
            end
            ST_CMP: begin
                if (i_sts.cmp.done) begin
                    o_ctl.clr_k = 1'b1;
                    if (i_sts.cmp.not_below) begin
                        o_ctl.set_found = 1'b1;
                        o_ctl.load_j    = 1'b1;
                    end else begin
                        o_ctl.inc_pos = 1'b1;
                    end
                end else begin
                    o_ctl.inc_k = 1'b1;
                end
            end
            ST_CP_RD: begin
                o_ctl.rd_copy = 1'b1;
            end
            ST_CP_WR: begin
                o_ctl.slot_we_copy = 1'b1;
                if (i_sts.k_end) begin
                    o_ctl.len_we_copy = 1'b1;
                    o_ctl.dec_j       = 1'b1;
                    o_ctl.clr_k       = 1'b1;
                end else begin
                    o_ctl.inc_k = 1'b1;
                end
            end
            ST_WR_RD: begin
                o_ctl.ready = 1'b0;
            end
            ST_WR_WR: begin
                o_ctl.slot_we_store = 1'b1;
                if (i_sts.k_end) begin
                    o_ctl.len_we_store = 1'b1;
                    o_ctl.inc_count    = 1'b1;
                end else begin
                    o_ctl.inc_k = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.load_out  = 1'b1;
                    o_ctl.clr_stage = 1'b1;
                end
            end
            default: o_ctl = '0;
        endcase
    end

endmodule

// ----- design/bounded_sorted_string_insert.sv -----
// Sequence: a plain byte is taken into the staging buffer; a last byte starts a
//   byte-wise search of the slots, then each slot below the insert point is moved
//   down a full row, the string is stored (not if not inserted) and the result word is loaded.
// Throughput: one string at a time; the byte store, length store and staging
//   buffer each have one read and one write port, which sets the pace of each phase.
// Reset: synchronous, active low; the list is empty and the input side ready at once.
// ----------------------------------------------------------------------------
// bounded_sorted_string_insert
// Collects a string byte by byte and inserts it into a bounded sorted list.
// ----------------------------------------------------------------------------
module bounded_sorted_string_insert
    import bssi_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: char_code [7:0]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    // tdata: inserted [0], position [4:1], occupied [9:5], truncated [10]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CHAR_W = $clog2(MAX_CHARS);
    localparam int LEN_W  = $clog2(MAX_CHARS + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ROW_D  = SLOTS * (2 ** CHAR_W);

    t_seq_ctl w_ctl;
    t_seq_sts w_sts;
    t_cmp_res w_cmp;

    logic [LEN_W-1:0]  r_stlen;
    logic              r_ovf;
    logic [CHAR_W-1:0] r_k;
    logic [CNT_W-1:0]  r_pos;
    logic [SLOT_W-1:0] r_j;
    logic              r_found;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              w_accept;
    logic              w_full;
    logic [SLOT_W-1:0] w_pos_idx;
    logic [SLOT_W-1:0] w_jstart;
    logic [SLOT_W-1:0] w_jm1;

    logic                     w_stage_we;
    logic [7:0]               w_stage_rdata;
    logic                     w_slot_we;
    logic [SLOT_W+CHAR_W-1:0] w_slot_waddr;
    logic [SLOT_W+CHAR_W-1:0] w_slot_raddr;
    logic [7:0]               w_slot_wdata;
    logic [7:0]               w_slot_rdata;
    logic                     w_len_we;
    logic [SLOT_W-1:0]        w_len_waddr;
    logic [SLOT_W-1:0]        w_len_raddr;
    logic [LEN_W-1:0]         w_len_wdata;
    logic [LEN_W-1:0]         w_len_rdata;

    logic [31:0]           w_cnt32;
    logic [31:0]           w_pos32;
    logic [OCC_W-1:0]      w_occ;
    logic [POS_W-1:0]      w_position;

    // handshake and index helpers
    assign w_accept  = s_axis_tvalid && w_ctl.ready;
    assign w_full    = r_count == CNT_W'(SLOTS);
    assign w_pos_idx = r_pos[SLOT_W-1:0];
    assign w_jstart  = w_full ? SLOT_W'(SLOTS - 1) : r_count[SLOT_W-1:0];
    assign w_jm1     = r_j - SLOT_W'(1);

    // status to the sequencer
    always_comb begin
        w_sts          = '0;
        w_sts.accept   = w_accept;
        w_sts.last     = s_axis_tlast;
        w_sts.at_tail  = r_pos == r_count;
        w_sts.full     = w_full;
        w_sts.cmp      = w_cmp;
        w_sts.k_end    = r_k == CHAR_W'(MAX_CHARS - 1);
        w_sts.start_eq = w_jstart == w_pos_idx;
        w_sts.next_eq  = w_jm1 == w_pos_idx;
        w_sts.out_free = !r_out_valid || m_axis_tready;
    end

    bssi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    bssi_cmp #(
        .CHAR_W (CHAR_W),
        .LEN_W  (LEN_W)
    ) u_cmp (
        .i_slot_byte  (w_slot_rdata),
        .i_stage_byte (w_stage_rdata),
        .i_k          (r_k),
        .i_slot_len   (w_len_rdata),
        .i_stage_len  (r_stlen),
        .o_res        (w_cmp)
    );

    // staging buffer for the string being entered
    assign w_stage_we = w_accept && (r_stlen != LEN_W'(MAX_CHARS));

    bssi_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHARS)
    ) u_stage_ram (
        .i_clk   (i_clk),
        .i_we    (w_stage_we),
        .i_waddr (r_stlen[CHAR_W-1:0]),
        .i_wdata (s_axis_tdata[7:0]),
        .i_raddr (r_k),
        .o_rdata (w_stage_rdata)
    );

    // slot byte store, one padded row per slot
    assign w_slot_we    = w_ctl.slot_we_copy || w_ctl.slot_we_store;
    assign w_slot_waddr = w_ctl.slot_we_copy ? {r_j, r_k} : {w_pos_idx, r_k};
    assign w_slot_wdata = w_ctl.slot_we_copy ? w_slot_rdata : w_stage_rdata;
    assign w_slot_raddr = w_ctl.rd_copy ? {w_jm1, r_k} : {w_pos_idx, r_k};

    bssi_ram #(
        .WIDTH (8),
        .DEPTH (ROW_D)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_slot_wdata),
        .i_raddr (w_slot_raddr),
        .o_rdata (w_slot_rdata)
    );

    // slot length store
    assign w_len_we    = w_ctl.len_we_copy || w_ctl.len_we_store;
    assign w_len_waddr = w_ctl.len_we_copy ? r_j : w_pos_idx;
    assign w_len_wdata = w_ctl.len_we_copy ? w_len_rdata : r_stlen;
    assign w_len_raddr = w_ctl.rd_copy ? w_jm1 : w_pos_idx;

    bssi_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_len_we),
        .i_waddr (w_len_waddr),
        .i_wdata (w_len_wdata),
        .i_raddr (w_len_raddr),
        .o_rdata (w_len_rdata)
    );

    // staging length and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stlen <= '0;
            r_ovf   <= 1'b0;
        end else if (w_ctl.clr_stage) begin
            r_stlen <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            if (r_stlen != LEN_W'(MAX_CHARS)) begin
                r_stlen <= r_stlen + LEN_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // byte, slot and move indices
    always_ff @(posedge i_clk) begin
        if (w_ctl.clr_k) begin
            r_k <= '0;
        end else if (w_ctl.inc_k) begin
            r_k <= r_k + CHAR_W'(1);
        end
        if (w_ctl.clr_pos) begin
            r_pos <= '0;
        end else if (w_ctl.inc_pos) begin
            r_pos <= r_pos + CNT_W'(1);
        end
        if (w_ctl.load_j) begin
            r_j <= w_jstart;
        end else if (w_ctl.dec_j) begin
            r_j <= w_jm1;
        end
        if (w_ctl.set_found) begin
            r_found <= 1'b1;
        end else if (w_ctl.clr_found) begin
            r_found <= 1'b0;
        end
    end

    // fill count of the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_ctl.inc_count && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // result word fields
    assign w_cnt32    = 32'(r_count);
    assign w_pos32    = 32'(r_pos);
    assign w_occ      = (w_cnt32 > OCC_MAX) ? OCC_W'(OCC_MAX) : w_cnt32[OCC_W-1:0];
    assign w_position = r_found ? w_pos32[POS_W-1:0] : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load_out) begin
            r_out_data <= OUT_DATA_W'({r_ovf, w_occ, w_position, r_found});
        end
    end

    assign s_axis_tready = w_ctl.ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- design/bssi_checker.sv -----
// ----------------------------------------------------------------------------
// bssi_checker
// Port level checks for the bounded sorted string insert block.
// ----------------------------------------------------------------------------
module bssi_checker
    import bssi_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // after reset the list is empty, nothing pending and input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after reset");

    // a word not inserted carries no position
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == 4'd0))
        else $error("position set on a word not inserted");

    // a last byte starts the insertion and closes the input side
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input open during insertion");

    // a result only follows an insertion pass
    a_result_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result word without insertion pass");

endmodule

bind bounded_sorted_string_insert bssi_checker u_bssi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bounded_sorted_string_insert. After reset a directed table
// covers equal strings, prefixes, zero bytes and an overlong string. After it
// comes random string traffic with shared prefixes and bursty input. The
// receiver stalls in shifting patterns, with one long hold-off. Each status
// word is checked field by field against the table or an in-bench model of the list.
// ----------------------------------------------------------------------------
module tb_top;
    import bssi_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int MAX_CHARS   = MAX_CHARS_DEF;
    localparam int RAND_WORDS  = 1000;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 64;

    // status word layout, lowest bit last
    typedef struct packed {
        logic [OUT_DATA_W-POS_W-OCC_W-3:0] spare;
        logic                              truncated;
        logic [OCC_W-1:0]                  occupied;
        logic [POS_W-1:0]                  position;
        logic                              inserted;
    } t_ins_status;

    // one row of the directed table: code repeated reps times, flag on the final copy
    typedef struct {
        logic [7:0]  code;
        int          reps;
        logic        last;
        bit          typed;
        t_ins_status want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    bounded_sorted_string_insert #(
        .SLOTS     (SLOTS),
        .MAX_CHARS (MAX_CHARS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // char_code [7:0]
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // inserted, position, occupied, truncated
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the list
    logic [7:0]  slot_text [SLOTS][MAX_CHARS];
    int          slot_len  [SLOTS];
    bit          slot_used [SLOTS];
    logic [7:0]  stage_text [MAX_CHARS];
    int          stage_len;
    bit          stage_over;

    t_ins_status status_q [$];

    int errors;
    int words_sent;
    int strings_done;
    int stored_cnt;
    int rejected_cnt;
    int trunc_cnt;
    int burst_left;
    int idle_cycles;

    // directed table
    t_stim_row dir_rows [8] = '{
        '{8'h80,  1, 1'b1, 1'b1, {5'd0, 1'b0, 5'd1, 4'd0, 1'b1}},  // first string, empty list
        '{8'h80,  1, 1'b1, 1'b1, {5'd0, 1'b0, 5'd2, 4'd0, 1'b1}},  // equal string goes in front
        '{8'h80,  1, 1'b0, 1'b0, '0},
        '{8'h00,  1, 1'b1, 1'b0, '0},                              // zero byte, longer than prefix
        '{8'hff, 17, 1'b1, 1'b1, {5'd0, 1'b1, 5'd4, 4'd3, 1'b1}},  // overlong, sorts last
        '{8'h00,  1, 1'b1, 1'b0, '0},                              // lowest possible string
        '{8'h7f,  1, 1'b0, 1'b0, '0},
        '{8'h01,  1, 1'b1, 1'b0, '0}
    };

    // stored slot s sorts at or above the staged string
    function automatic bit slot_at_or_above(input int s);
        int n;
        n = (slot_len[s] < stage_len) ? slot_len[s] : stage_len;
        for (int k = 0; k < n; k++) begin
            if (slot_text[s][k] != stage_text[k])
                return slot_text[s][k] > stage_text[k];
        end
        return slot_len[s] >= stage_len;
    endfunction

    // take one byte into the list mirror, give the status word if the string ends
    function automatic t_ins_status list_insert_byte(input logic [7:0] code, input logic last,
                                                     output bit has_status);
        t_ins_status st;
        int          pos;
        int          count;
        bit          found;
        st = '0;
        has_status = 1'b0;
        if (stage_len < MAX_CHARS) begin
            stage_text[stage_len] = code;
            stage_len++;
        end else begin
            stage_over = 1'b1;
        end
        if (!last)
            return st;

        // first slot that is free or not below the new string
        pos = 0;
        found = 1'b0;
        while (pos < SLOTS && !found) begin
            if (!slot_used[pos] || slot_at_or_above(pos))
                found = 1'b1;
            else
                pos++;
        end

        // shift the tail down and store
        if (found) begin
            for (int j = SLOTS - 1; j > pos; j--) begin
                slot_text[j] = slot_text[j-1];
                slot_len[j]  = slot_len[j-1];
                slot_used[j] = slot_used[j-1];
            end
            slot_text[pos] = stage_text;
            slot_len[pos]  = stage_len;
            slot_used[pos] = 1'b1;
        end

        count = 0;
        for (int j = 0; j < SLOTS; j++)
            if (slot_used[j])
                count++;
        if (count > OCC_MAX)
            count = OCC_MAX;

        st.inserted  = found;
        st.position  = found ? pos[POS_W-1:0] : '0;
        st.occupied  = count[OCC_W-1:0];
        st.truncated = stage_over;

        strings_done++;
        if (found) stored_cnt++; else rejected_cnt++;
        if (stage_over) trunc_cnt++;
        stage_len  = 0;
        stage_over = 1'b0;
        has_status = 1'b1;
        return st;
    endfunction

    // offer one word, wait for it to be taken, then keep bursting or pause
    task automatic push_word(input logic [7:0] code, input logic last, input bit typed,
                             input t_ins_status want);
        t_ins_status st;
        bit          has_status;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        st = list_insert_byte(code, last, has_status);
        if (has_status)
            status_q.push_back(typed ? want : st);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // field compare with report
    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // receiver: check status words and drive its own stall pattern
    int          results_seen;
    int          hold_left;
    bit          hold_done;
    int          stall_mode;
    int          mode_left;
    t_ins_status want_st;
    t_ins_status got_st;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_st = m_axis_tdata;
                results_seen++;
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected status word, expected none, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want_st = status_q.pop_front();
                    check_field("inserted",  int'(want_st.inserted),  int'(got_st.inserted));
                    check_field("position",  int'(want_st.position),  int'(got_st.position));
                    check_field("occupied",  int'(want_st.occupied),  int'(got_st.occupied));
                    check_field("truncated", int'(want_st.truncated), int'(got_st.truncated));
                end
            end

            // one long hold-off, otherwise shifting stall patterns
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 30) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 200);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: begin
                        m_axis_tready <= 1'b1;
                    end
                    1: begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_axis_tready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_axis_tready <= ~m_axis_tready;
                    end
                endcase
            end
        end
    end

    // cycles since the last word moved on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top: done, errors");
        $finish;
    end

    // stimulus
    initial begin
        logic [7:0] text [$];
        int         kind;
        int         n_used;
        int         s;
        int         p;
        int         n;

        errors = 0;
        words_sent = 0;
        strings_done = 0;
        stored_cnt = 0;
        rejected_cnt = 0;
        trunc_cnt = 0;
        burst_left = 0;
        results_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        stall_mode = 0;
        mode_left = 0;
        stage_len = 0;
        stage_over = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            slot_used[j] = 1'b0;
            slot_len[j]  = 0;
        end

        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[r]) begin
            for (int i = 0; i < dir_rows[r].reps; i++)
                push_word(dir_rows[r].code, dir_rows[r].last && (i == dir_rows[r].reps - 1),
                          dir_rows[r].typed, dir_rows[r].want);
        end

        // random strings
        while (words_sent < RAND_WORDS + 24) begin
            text.delete();
            kind = $urandom_range(0, 9);
            n_used = 0;
            for (int j = 0; j < SLOTS; j++)
                if (slot_used[j])
                    n_used++;
            if (kind == 0) begin
                // overlong
                n = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 4);
                repeat (n) text.push_back(8'($urandom_range(0, 255)));
            end else if (kind <= 4 && n_used > 0) begin
                // shares a prefix with a stored string, often equal to it
                s = $urandom_range(0, n_used - 1);
                p = $urandom_range(0, slot_len[s]);
                for (int k = 0; k < p; k++)
                    text.push_back(slot_text[s][k]);
                if (p > 0 && $urandom_range(0, 2) == 0)
                    text[p-1] = text[p-1] + ($urandom_range(0, 1) ? 8'd1 : 8'hff);
                repeat ($urandom_range(0, 2)) text.push_back(8'($urandom_range(0, 255)));
            end else if (kind == 5) begin
                // bytes of all ones or all zeros, up to the full length
                n = $urandom_range(1, MAX_CHARS);
                repeat (n) text.push_back($urandom_range(0, 1) ? 8'hff : 8'h00);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) text.push_back(8'($urandom_range(0, 255)));
            end
            if (text.size() == 0)
                text.push_back(8'($urandom_range(0, 255)));
            foreach (text[k])
                push_word(text[k], k == text.size() - 1, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("tb_top: %0d bytes in %0d strings, %0d stored, %0d turned away on a full list",
                 words_sent, strings_done, stored_cnt, rejected_cnt);
        $display("tb_top: %0d strings cut at %0d bytes, %0d status words checked",
                 trunc_cnt, MAX_CHARS, results_seen);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
